// ===== hdl/tmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsd_pkg: shared types and constants for the template matcher
// Register indexes, field widths, parameter defaults and the control word
// passed from the sequencer to the score accumulator.
// ----------------------------------------------------------------------------
package tmsd_pkg;

  localparam int DEF_MAX_IMAGE_WIDTH     = 1024;
  localparam int DEF_MAX_TEMPLATE_WIDTH  = 16;
  localparam int DEF_MAX_TEMPLATE_HEIGHT = 16;

  localparam int ROW_LIMIT  = 1024;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SQ_W       = 2 * CH_W;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int SCORE_W    = 26;
  localparam int COORD_W    = 10;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_TEMPLATE_WIDTH  = 3'd2,
    REG_TEMPLATE_HEIGHT = 3'd3,
    REG_THREE_CHANNELS  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic clear;  // start a new score
    logic valid;  // memory read data valid this cycle
    logic three;  // add the second and third channels
  } acc_ctrl_t;

endpackage

// ===== hdl/tmsd_sq_acc.sv =====
// ----------------------------------------------------------------------------
// tmsd_sq_acc: squared difference and accumulate
// Takes one template word and one image word per cycle, squares the
// per-channel differences in a registered stage and sums them into the score.
// ----------------------------------------------------------------------------
module tmsd_sq_acc
  import tmsd_pkg::*;
#(
  parameter int ACC_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  acc_ctrl_t        ctrl,
  input  logic [PIX_W-1:0] tpl_pix,
  input  logic [PIX_W-1:0] img_pix,
  output logic [ACC_W-1:0] acc,
  output logic             busy
);

  logic             sq_vld_r;
  logic [SQ_W-1:0]  sq_r [3];
  logic [ACC_W-1:0] acc_r;
  logic [CH_W-1:0]  diff [3];
  logic [SQ_W+1:0]  sq_sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (tpl_pix[k*CH_W +: CH_W] > img_pix[k*CH_W +: CH_W]) begin
        diff[k] = tpl_pix[k*CH_W +: CH_W] - img_pix[k*CH_W +: CH_W];
      end else begin
        diff[k] = img_pix[k*CH_W +: CH_W] - tpl_pix[k*CH_W +: CH_W];
      end
    end
  end

  assign sq_sum = (SQ_W+2)'(sq_r[0]) + (SQ_W+2)'(sq_r[1]) + (SQ_W+2)'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      sq_vld_r <= ctrl.valid;
      if (ctrl.clear) begin
        acc_r <= '0;
      end else if (sq_vld_r) begin
        acc_r <= acc_r + ACC_W'(sq_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      sq_r[0] <= diff[0] * diff[0];
      sq_r[1] <= ctrl.three ? diff[1] * diff[1] : '0;
      sq_r[2] <= ctrl.three ? diff[2] * diff[2] : '0;
    end
  end

  assign acc  = acc_r;
  assign busy = sq_vld_r;

endmodule

// ===== hdl/template_match_sum_sq_diff.sv =====
// ----------------------------------------------------------------------------
// template_match_sum_sq_diff: sum-of-squared-differences template matcher
// Template words (kind 0) load the template store in raster order; image
// words (kind 1) stream in raster order into the row buffer memory. Each image
// word that completes a window inside the image yields one result word with
// the window's top-left position, its score and a last-position flag.
// Both channels are valid/ready. in_ready is high only while the sequencer is
// idle. For a scoring word the window is read one template position per cycle
// from the template store and row buffer memory (one read port each), then the
// square/accumulate pipeline drains. The result sits in an output register; if
// the receiver stalls, the next result waits in the sequencer until the last
// one is taken. Reset returns the registers to 640 x 480, an 8 x 8 gray
// template, and clears the counters; memories are not cleared. Configuration
// is written through cfg_we / cfg_index / cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module template_match_sum_sq_diff
  import tmsd_pkg::*;
#(
  parameter int MAX_IMAGE_WIDTH     = DEF_MAX_IMAGE_WIDTH,
  parameter int MAX_TEMPLATE_WIDTH  = DEF_MAX_TEMPLATE_WIDTH,
  parameter int MAX_TEMPLATE_HEIGHT = DEF_MAX_TEMPLATE_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [CH_W-1:0]       in_chan_a,
  input  logic [CH_W-1:0]       in_chan_b,
  input  logic [CH_W-1:0]       in_chan_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    out_match_x,
  output logic [COORD_W-1:0]    out_match_y,
  output logic [SCORE_W-1:0]    out_score,
  output logic                  out_last_position
);

  localparam int IW_W   = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int CW     = (IW_W > CFG_DATA_W ? IW_W : CFG_DATA_W) + 1;
  localparam int COL_W  = $clog2(MAX_IMAGE_WIDTH);
  localparam int ROW_W  = $clog2(ROW_LIMIT);
  localparam int SLOT_W = $clog2(MAX_TEMPLATE_HEIGHT);
  localparam int TW_W   = $clog2(MAX_TEMPLATE_WIDTH);
  localparam int TH_W   = $clog2(MAX_TEMPLATE_HEIGHT);
  localparam int TPL_N  = MAX_TEMPLATE_WIDTH * MAX_TEMPLATE_HEIGHT;
  localparam int TA_W   = $clog2(TPL_N);
  localparam int LC_W   = $clog2(TPL_N + 1);
  localparam longint ACC_MAX = longint'(TPL_N) * 3 * 65025;
  localparam int ACC_W  = $clog2(ACC_MAX + 1);
  localparam int SW     = ACC_W > SCORE_W ? ACC_W : SCORE_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  // configuration
  logic [CFG_DATA_W-1:0] img_w_r, img_h_r;
  logic [4:0]            tpl_w_r, tpl_h_r;
  logic                  three_r;

  // stream counters
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LC_W-1:0]   lc_r;

  // window walk
  state_t            state_r;
  logic [TW_W-1:0]   j_r;
  logic [TH_W-1:0]   i_r;
  logic [TA_W-1:0]   taddr_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic [COL_W-1:0]  rd_col_r;
  logic [COL_W-1:0]  x0_r;
  logic [ROW_W-1:0]  y0_r;
  logic              last_r;
  logic              rd_vld_r;
  logic [PIX_W-1:0]  tpl_q_r, pix_q_r;

  logic              out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [SCORE_W-1:0] out_score_r;
  logic              out_last_r;

  logic [PIX_W-1:0] tpl_mem [TPL_N];
  logic [PIX_W-1:0] row_mem [MAX_TEMPLATE_HEIGHT][MAX_IMAGE_WIDTH];

  logic [CW-1:0]    iw_c, ih_c, tw_c, th_c, iw_e, ih_e, tw_e, th_e;
  logic [CW-1:0]    col_e1, row_e1, th_m1, slot_e, x0_c, y0_c, base_c;
  logic [2*CW-1:0]  tpl_cnt;
  logic             in_fire, is_last, do_emit, issue, row_end, walk_col_end, walk_end;
  logic [PIX_W-1:0] in_pix;
  logic [ACC_W-1:0] acc;
  logic             acc_busy;
  acc_ctrl_t        acc_ctrl;
  logic [SW-1:0]    acc_w;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic [SLOT_W-1:0] slot_nxt;

  assign in_pix  = {in_chan_c, in_chan_b, in_chan_a};
  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;

  // clamp registers
  assign iw_e = CW'(img_w_r);
  assign ih_e = CW'(img_h_r);
  assign tw_e = CW'(tpl_w_r);
  assign th_e = CW'(tpl_h_r);
  assign iw_c = (iw_e < CW'(2)) ? CW'(2) :
                (iw_e > CW'(MAX_IMAGE_WIDTH)) ? CW'(MAX_IMAGE_WIDTH) : iw_e;
  assign ih_c = (ih_e < CW'(2)) ? CW'(2) :
                (ih_e > CW'(ROW_LIMIT)) ? CW'(ROW_LIMIT) : ih_e;
  assign tw_c = (tw_e < CW'(1)) ? CW'(1) :
                (tw_e > CW'(MAX_TEMPLATE_WIDTH)) ? CW'(MAX_TEMPLATE_WIDTH) : tw_e;
  assign th_c = (th_e < CW'(1)) ? CW'(1) :
                (th_e > CW'(MAX_TEMPLATE_HEIGHT)) ? CW'(MAX_TEMPLATE_HEIGHT) : th_e;
  assign tpl_cnt = (2*CW)'(tw_c) * (2*CW)'(th_c);

  assign col_e1  = CW'(col_r) + CW'(1);
  assign row_e1  = CW'(row_r) + CW'(1);
  assign row_end = (col_e1 >= iw_c);
  assign is_last = row_end && (row_e1 >= ih_c);
  assign do_emit = (tw_c < iw_c) && (th_c < ih_c) && (col_e1 >= tw_c) && (row_e1 >= th_c)
                && (CW'(col_r) < iw_c) && (CW'(row_r) < ih_c);
  assign x0_c    = col_e1 - tw_c;
  assign y0_c    = row_e1 - th_c;

  // row slot holding the window's top line
  assign th_m1   = th_c - CW'(1);
  assign slot_e  = CW'(slot_r);
  assign base_c  = (slot_e >= th_m1) ? slot_e - th_m1 : slot_e + CW'(MAX_TEMPLATE_HEIGHT) - th_m1;

  always_comb begin
    col_nxt  = COL_W'(col_e1);
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (row_end) begin
      col_nxt = '0;
      if (row_e1 >= ih_c) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = ROW_W'(row_e1);
        slot_nxt = (CW'(slot_r) == CW'(MAX_TEMPLATE_HEIGHT - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  assign issue        = (state_r == S_RUN);
  assign walk_col_end = (CW'(j_r) == tw_c - CW'(1));
  assign walk_end     = walk_col_end && (CW'(i_r) == th_m1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= CFG_DATA_W'(640);
      img_h_r <= CFG_DATA_W'(480);
      tpl_w_r <= 5'd8;
      tpl_h_r <= 5'd8;
      three_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     img_w_r <= cfg_wdata;
        REG_IMAGE_HEIGHT:    img_h_r <= cfg_wdata;
        REG_TEMPLATE_WIDTH:  tpl_w_r <= cfg_wdata[4:0];
        REG_TEMPLATE_HEIGHT: tpl_h_r <= cfg_wdata[4:0];
        REG_THREE_CHANNELS:  three_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      lc_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (!in_kind) begin
              if ((2*CW)'(lc_r) < tpl_cnt) begin
                lc_r <= lc_r + 1'b1;
              end
              col_r  <= '0;
              row_r  <= '0;
              slot_r <= '0;
            end else begin
              lc_r   <= '0;
              col_r  <= col_nxt;
              row_r  <= row_nxt;
              slot_r <= slot_nxt;
              if (do_emit) begin
                state_r <= S_RUN;
              end
            end
          end
        end
        S_RUN: begin
          if (walk_end) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld_r && !acc_busy) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // walk counters and output payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_fire && in_kind && do_emit) begin
      j_r       <= '0;
      i_r       <= '0;
      taddr_r   <= '0;
      rd_slot_r <= SLOT_W'(base_c);
      rd_col_r  <= COL_W'(x0_c);
      x0_r      <= COL_W'(x0_c);
      y0_r      <= ROW_W'(y0_c);
      last_r    <= is_last;
    end else if (issue) begin
      taddr_r <= taddr_r + 1'b1;
      if (walk_col_end) begin
        j_r      <= '0;
        i_r      <= i_r + 1'b1;
        rd_col_r <= x0_r;
        rd_slot_r <= (CW'(rd_slot_r) == CW'(MAX_TEMPLATE_HEIGHT - 1)) ? '0 : rd_slot_r + 1'b1;
      end else begin
        j_r      <= j_r + 1'b1;
        rd_col_r <= rd_col_r + 1'b1;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_x_r     <= COORD_W'(x0_r);
      out_y_r     <= COORD_W'(y0_r);
      out_score_r <= (acc_w > SW'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(acc_w);
      out_last_r  <= last_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_fire && !in_kind && ((2*CW)'(lc_r) < tpl_cnt)) begin
      tpl_mem[lc_r[TA_W-1:0]] <= in_pix;
    end
    if (issue) begin
      tpl_q_r <= tpl_mem[taddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_kind) begin
      row_mem[slot_r][col_r] <= in_pix;
    end
    if (issue) begin
      pix_q_r <= row_mem[rd_slot_r][rd_col_r];
    end
  end

  assign acc_ctrl.clear = in_fire;
  assign acc_ctrl.valid = rd_vld_r;
  assign acc_ctrl.three = three_r;

  tmsd_sq_acc #(
    .ACC_W(ACC_W)
  ) u_sq_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (acc_ctrl),
    .tpl_pix(tpl_q_r),
    .img_pix(pix_q_r),
    .acc    (acc),
    .busy   (acc_busy)
  );

  assign acc_w = SW'(acc);

  assign out_valid         = out_valid_r;
  assign out_match_x       = out_x_r;
  assign out_match_y       = out_y_r;
  assign out_score         = out_score_r;
  assign out_last_position = out_last_r;

`ifndef NO_ASSERTIONS
  a_read_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_RUN))
    else $error("memory read data without a window walk");

  a_score_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_score_r <= SCORE_MAX))
    else $error("score out of range");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(col_r) < CW'(MAX_IMAGE_WIDTH))
    else $error("column counter beyond row buffer");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |=> !in_ready || !acc_busy)
    else $error("input taken while score pipeline busy");
`endif

endmodule

// ===== dv/template_match_sum_sq_diff_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// template_match_sum_sq_diff_test: self-checking bench for the SSD matcher
// Loads templates and streams raster images over valid/ready, predicts every
// window score in the bench, and checks each result word in order. Covers
// register clamping, template overflow, oversize templates, gray and color
// modes, a full-width row, and random geometries with random stalls.
// ----------------------------------------------------------------------------
module template_match_sum_sq_diff_test;
  import tmsd_pkg::*;

  localparam int IMG_MAX  = 1024;
  localparam int TPL_MAXW = 16;
  localparam int TPL_MAXH = 16;
  localparam int DRAIN    = 300;
  localparam bit TPL_WORD = 1'b0;
  localparam bit IMG_WORD = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SCORE_W-1:0] score;
    logic               last;
  } match_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = 1'b0;
  logic [CH_W-1:0]       in_chan_a = '0;
  logic [CH_W-1:0]       in_chan_b = '0;
  logic [CH_W-1:0]       in_chan_c = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_W-1:0]    out_match_x;
  logic [COORD_W-1:0]    out_match_y;
  logic [SCORE_W-1:0]    out_score;
  logic                  out_last_position;

  template_match_sum_sq_diff uut (.*);

  always #10 clk = ~clk;

  // bench copy of the matcher state
  int unsigned img_w = 640, img_h = 480, tpl_w = 8, tpl_h = 8;
  bit          color = 1'b0;
  logic [PIX_W-1:0] tpl_mem [TPL_MAXW*TPL_MAXH];
  logic [PIX_W-1:0] line_mem [TPL_MAXH][IMG_MAX];
  int unsigned load_cnt = 0, col_cnt = 0, row_cnt = 0;

  match_t expected_matches[$];
  int     mismatches = 0;
  bit     calm = 1'b0;
  int     random_words = 0;

  function automatic int unsigned clampi(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned sqd(logic [CH_W-1:0] t, logic [CH_W-1:0] p);
    int unsigned d;
    d = t > p ? t - p : p - t;
    return d * d;
  endfunction

  // advance the bench state by one accepted word; queue a match if one is due
  function automatic void predict_match(bit kind, logic [PIX_W-1:0] pix);
    int unsigned iw, ih, tw, th, col, row, x0, y0;
    longint unsigned sum;
    logic [PIX_W-1:0] t, p;
    match_t m;
    iw = clampi(img_w, 2, IMG_MAX);
    ih = clampi(img_h, 2, ROW_LIMIT);
    tw = clampi(tpl_w, 1, TPL_MAXW);
    th = clampi(tpl_h, 1, TPL_MAXH);
    if (kind == TPL_WORD) begin
      if (load_cnt < tw * th) begin
        tpl_mem[load_cnt] = pix;
        load_cnt++;
      end
      col_cnt = 0;
      row_cnt = 0;
      return;
    end
    load_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    if (col >= IMG_MAX) col = IMG_MAX - 1;
    line_mem[row % TPL_MAXH][col] = pix;
    if (tw < iw && th < ih && col + 1 >= tw && row + 1 >= th && col < iw && row < ih) begin
      x0 = col + 1 - tw;
      y0 = row + 1 - th;
      sum = 0;
      for (int i = 0; i < th; i++)
        for (int j = 0; j < tw; j++) begin
          t = tpl_mem[i * tw + j];
          p = line_mem[(y0 + i) % TPL_MAXH][x0 + j];
          sum += sqd(t[7:0], p[7:0]);
          if (color) sum += sqd(t[15:8], p[15:8]) + sqd(t[23:16], p[23:16]);
        end
      if (sum > SCORE_MAX) sum = SCORE_MAX;
      m.x = x0[COORD_W-1:0];
      m.y = y0[COORD_W-1:0];
      m.score = sum[SCORE_W-1:0];
      m.last = (col + 1 >= iw) && (row + 1 >= ih);
      expected_matches.push_back(m);
    end
    if (col + 1 >= iw) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= ih) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
  endfunction

  task automatic send_word(bit kind, logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                           logic [CH_W-1:0] c);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_chan_a <= a;
    in_chan_b <= b;
    in_chan_c <= c;
    do @(posedge clk); while (!in_ready);
    predict_match(kind, {c, b, a});
  endtask

  // drop valid, let every match drain, then let a silent scoring pass finish
  task automatic wait_idle();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_matches.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_IMAGE_WIDTH:     img_w = value & 11'h7FF;
      REG_IMAGE_HEIGHT:    img_h = value & 11'h7FF;
      REG_TEMPLATE_WIDTH:  tpl_w = value & 5'h1F;
      REG_TEMPLATE_HEIGHT: tpl_h = value & 5'h1F;
      REG_THREE_CHANNELS:  color = value & 1;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned iw, int unsigned ih, int unsigned tw,
                              int unsigned th, bit three);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_TEMPLATE_WIDTH, tw);
    write_reg(REG_TEMPLATE_HEIGHT, th);
    write_reg(REG_THREE_CHANNELS, three);
  endtask

  function automatic logic [CH_W-1:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic load_template(int n);
    for (int i = 0; i < n; i++) send_word(TPL_WORD, rnd_sample(), rnd_sample(), rnd_sample());
  endtask

  task automatic stream_image(int n);
    for (int i = 0; i < n; i++) send_word(IMG_WORD, rnd_sample(), rnd_sample(), rnd_sample());
  endtask

  task automatic test_gray_extremes();
    set_geometry(3, 3, 2, 2, 1'b0);
    repeat (4) send_word(TPL_WORD, 8'hFF, 8'h00, 8'hFF);
    for (int i = 0; i < 9; i++)
      send_word(IMG_WORD, (i % 2) ? 8'hFF : 8'h00, 8'hFF, 8'h00);
  endtask

  task automatic test_color_extremes();
    set_geometry(3, 2, 2, 1, 1'b1);
    send_word(TPL_WORD, 8'hFF, 8'hFF, 8'hFF);
    send_word(TPL_WORD, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 6; i++) send_word(IMG_WORD, 8'h00, 8'hFF, 8'hAA);
  endtask

  task automatic test_template_overflow();
    set_geometry(4, 2, 2, 1, 1'b0);
    load_template(5);  // the last three are dropped
    stream_image(8);
  endtask

  task automatic test_oversize_template();
    set_geometry(4, 3, 4, 1, 1'b0);
    load_template(4);
    stream_image(12);
    set_geometry(4, 3, 1, 3, 1'b1);
    load_template(3);
    stream_image(12);
  endtask

  task automatic test_register_clamps();
    // sizes below the floor and above the ceiling
    set_geometry(0, 1, 0, 31, 1'b0);
    load_template(16);
    stream_image(6);
    set_geometry(1, 0, 0, 0, 1'b1);
    load_template(1);
    stream_image(6);
    // a full-width row on a clamped 1024-row image
    set_geometry(2047, 2047, 17, 1, 1'b1);
    load_template(16);
    stream_image(1100);
  endtask

  task automatic test_random_images();
    int unsigned iw, ih, tw, th, tpl_words, pixels;
    while (random_words < 520) begin
      iw = $urandom_range(2, 12);
      ih = $urandom_range(2, 8);
      tw = ($urandom_range(0, 9) == 0) ? iw : $urandom_range(1, (iw > 6) ? 5 : iw - 1);
      th = ($urandom_range(0, 9) == 0) ? ih : $urandom_range(1, (ih > 6) ? 5 : ih - 1);
      if (random_words > 400) calm = 1'b1;
      set_geometry(iw, ih, tw, th, $urandom_range(0, 1));
      tpl_words = tw * th + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
      load_template(tpl_words);
      random_words += tpl_words;
      repeat ($urandom_range(1, 2)) begin
        pixels = iw * ih;
        if ($urandom_range(0, 5) == 0) begin
          // break off mid-image and reload the whole template
          pixels = $urandom_range(1, pixels);
          stream_image(pixels);
          load_template(tw * th);
          random_words += tw * th;
          pixels = iw * ih;
        end
        stream_image(pixels);
        random_words += pixels;
      end
    end
  endtask

  // receiver stalls in bursts, none once the run goes calm
  initial begin
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 1)) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected match word x=%0d y=%0d score=%0d last=%0b",
                   out_match_x, out_match_y, out_score, out_last_position);
      end else begin
        want = expected_matches.pop_front();
        if (out_match_x !== want.x || out_match_y !== want.y ||
            out_score !== want.score || out_last_position !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("match mismatch: expected x=%0d y=%0d score=%0d last=%0b, got x=%0d y=%0d score=%0d last=%0b",
                     want.x, want.y, want.score, want.last,
                     out_match_x, out_match_y, out_score, out_last_position);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_gray_extremes();
    test_color_extremes();
    test_template_overflow();
    test_oversize_template();
    test_register_clamps();
    test_random_images();
    wait_idle();
    if (expected_matches.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
